[rtl/rpba_pkg.sv]
package rpba_pkg;

	localparam logic [7:0] FAIL_MAX = 8'd255;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_LARGE = 2'd1;
	localparam logic [1:0] ST_OOP   = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_RESET = 1'b1;

	localparam logic REG_MAX_ALLOC  = 1'b0;
	localparam logic REG_MAX_FAILED = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] req_size;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  pool_index;
		logic [11:0] byte_offset;
		logic        opened_new;
	} rsp_t;

	typedef enum logic [3:0] {
		U_IDLE,
		U_CHK_RST,
		U_CHK_LARGE,
		U_READ,
		U_EVAL,
		U_ADV,
		U_OPEN,
		U_LARGE,
		U_CLEAR
	} step_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_START,
		C_CMD_RST,
		C_LARGE,
		C_FIT,
		C_LAST
	} cond_t;

	typedef enum logic [2:0] {
		OP_ACCEPT,
		OP_NOP,
		OP_READ,
		OP_EVAL,
		OP_ADV,
		OP_OPEN,
		OP_LARGE,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} ucode_t;

	typedef struct packed {
		logic start;
		logic cmd_rst;
		logic oversize;
		logic fit;
		logic last;
	} flags_t;

	function automatic ucode_t ucode(step_t s);
		ucode_t w;
		unique case (s)
			U_IDLE:      w = '{OP_ACCEPT, C_START,   U_CHK_RST, U_IDLE};
			U_CHK_RST:   w = '{OP_NOP,    C_CMD_RST, U_CLEAR,   U_CHK_LARGE};
			U_CHK_LARGE: w = '{OP_NOP,    C_LARGE,   U_LARGE,   U_READ};
			U_READ:      w = '{OP_READ,   C_ALWAYS,  U_EVAL,    U_EVAL};
			U_EVAL:      w = '{OP_EVAL,   C_FIT,     U_IDLE,    U_ADV};
			U_ADV:       w = '{OP_ADV,    C_LAST,    U_OPEN,    U_READ};
			U_OPEN:      w = '{OP_OPEN,   C_ALWAYS,  U_IDLE,    U_IDLE};
			U_LARGE:     w = '{OP_LARGE,  C_ALWAYS,  U_IDLE,    U_IDLE};
			U_CLEAR:     w = '{OP_CLEAR,  C_ALWAYS,  U_IDLE,    U_IDLE};
			default:     w = '{OP_NOP,    C_ALWAYS,  U_IDLE,    U_IDLE};
		endcase
		return w;
	endfunction

endpackage

[rtl/rpba_mem.sv]
module rpba_mem import rpba_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IW    = 4,
	parameter int FW    = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [FW-1:0] wfill,
	input  logic [7:0]    wfail,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output logic [FW-1:0] rfill,
	output logic [7:0]    rfail
);

	logic [FW+7:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [FW+7:0]    rd_q;
	logic             rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wfill, wfail};
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	assign rfill = rvalid_q ? rd_q[FW+7:8] : '0;
	assign rfail = rvalid_q ? rd_q[7:0] : '0;

endmodule

[rtl/rpba_seq.sv]
module rpba_seq import rpba_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ucode_t ctrl,
	output logic   busy
);

	step_t step_q;
	step_t step_d;
	logic  take;

	always_comb begin
		unique case (ctrl.cond)
			C_ALWAYS:  take = 1'b1;
			C_START:   take = flags.start;
			C_CMD_RST: take = flags.cmd_rst;
			C_LARGE:   take = flags.oversize;
			C_FIT:     take = flags.fit;
			C_LAST:    take = flags.last;
			default:   take = 1'b1;
		endcase
		step_d = take ? ctrl.tgt_t : ctrl.tgt_f;
	end

	always_comb begin
		ctrl = ucode(step_q);
		busy = (step_q != U_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= U_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

[rtl/region_pool_bump_allocator_core.sv]
// A reset command steps through check-reset and clear; a large request through check-reset,
// check-large and large. An allocation walks the open sub-pools from the current one to the last;
// when none of them fits, the open step follows. Each sub-pool walked without a fit costs a
// read, an evaluate and an advance step; the one that fits ends after its evaluate step.
// One word at a time; a new start is taken in the cycle done is high. Results cannot be
// stalled. Async reset clears all sub-pools and the current pointer, opens one sub-pool.
module region_pool_bump_allocator_core import rpba_pkg::*; #(
	parameter int POOL_BYTES = 4096,
	parameter int NUM_POOLS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int FW = $clog2(POOL_BYTES + 1);
	localparam int IW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int OW = $clog2(NUM_POOLS + 1);

	ucode_t ctrl;
	flags_t flags;

	logic          cmd_q;
	logic [15:0]   size_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] next_cur_q;
	logic          skip_last_q;
	logic [IW-1:0] cur_q;
	logic [OW-1:0] open_q;
	logic [12:0]   max_alloc_q;
	logic [7:0]    max_failed_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic          mem_clr;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [FW-1:0] mem_wfill;
	logic [7:0]    mem_wfail;
	logic          mem_re;
	logic [FW-1:0] used;
	logic [7:0]    fail;

	logic [FW:0]   sum;
	logic [7:0]    fail_inc;
	logic          can_open;
	logic [IW-1:0] nidx;

	rpba_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	rpba_mem #(
		.DEPTH (NUM_POOLS),
		.IW    (IW),
		.FW    (FW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mem_clr),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wfill  (mem_wfill),
		.wfail  (mem_wfail),
		.re     (mem_re),
		.raddr  (idx_q),
		.rfill  (used),
		.rfail  (fail)
	);

	always_comb begin
		sum      = (FW+1)'(used) + (FW+1)'(size_q);
		fail_inc = (fail == FAIL_MAX) ? fail : fail + 8'd1;
		can_open = open_q < OW'(NUM_POOLS);
		nidx     = IW'(open_q);

		flags.start    = start;
		flags.cmd_rst  = (cmd_q == CMD_RESET);
		flags.oversize = (size_q > 16'(max_alloc_q)) || ({1'b0, size_q} > 17'(POOL_BYTES));
		flags.fit      = sum <= (FW+1)'(POOL_BYTES);
		flags.last     = (OW'(idx_q) + OW'(1)) == open_q;
	end

	always_comb begin
		mem_clr   = (ctrl.op == OP_CLEAR);
		mem_re    = (ctrl.op == OP_READ);
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wfill = used;
		mem_wfail = fail;
		unique case (ctrl.op)
			OP_EVAL: begin
				mem_we = 1'b1;
				if (flags.fit) begin
					mem_wfill = FW'(sum);
				end else begin
					mem_wfail = fail_inc;
				end
			end
			OP_OPEN: begin
				mem_we    = can_open;
				mem_waddr = nidx;
				mem_wfill = FW'(size_q);
				mem_wfail = '0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_ACCEPT && start) begin
			cmd_q  <= req.cmd;
			size_q <= req.req_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			next_cur_q   <= '0;
			skip_last_q  <= 1'b0;
			cur_q        <= '0;
			open_q       <= OW'(1);
			max_alloc_q  <= 13'd4095;
			max_failed_q <= 8'd4;
			done_q       <= 1'b0;
			rsp_q        <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MAX_ALLOC:  max_alloc_q  <= cfg_data;
					REG_MAX_FAILED: max_failed_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			unique case (ctrl.op)
				OP_ACCEPT: begin
					if (start) begin
						idx_q       <= cur_q;
						next_cur_q  <= cur_q;
						skip_last_q <= 1'b0;
					end
				end
				OP_EVAL: begin
					if (flags.fit) begin
						cur_q  <= next_cur_q;
						done_q <= 1'b1;
						rsp_q  <= '{ST_OK, 4'(idx_q), 12'(used), 1'b0};
					end else if (fail_inc > max_failed_q) begin
						if (!flags.last) begin
							next_cur_q <= idx_q + IW'(1);
						end else begin
							next_cur_q  <= idx_q;
							skip_last_q <= 1'b1;
						end
					end
				end
				OP_ADV: begin
					idx_q <= idx_q + IW'(1);
				end
				OP_OPEN: begin
					done_q <= 1'b1;
					if (can_open) begin
						open_q <= open_q + OW'(1);
						cur_q  <= skip_last_q ? nidx : next_cur_q;
						rsp_q  <= '{ST_OK, 4'(nidx), 12'd0, 1'b1};
					end else begin
						cur_q <= next_cur_q;
						rsp_q <= '{ST_OOP, 4'd0, 12'd0, 1'b0};
					end
				end
				OP_LARGE: begin
					done_q <= 1'b1;
					rsp_q  <= '{ST_LARGE, 4'd0, 12'd0, 1'b0};
				end
				OP_CLEAR: begin
					cur_q  <= '0;
					done_q <= 1'b1;
					rsp_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while sequencer busy");

	a_cur_open: assert property (@(posedge clk) disable iff (!arst_n)
		OW'(cur_q) < open_q) else $error("current pool beyond open pools");

	a_open_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> open_q >= $past(open_q)) else $error("open pool count shrank");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word not started");

endmodule
